### design/gfba_pkg.sv
// Shared types and codes for the grouped free block allocator.
// No dependencies; imported by every module of the block.

package gfba_pkg;

	localparam int BW = 10;	// block number width
	localparam int GW = 5;	// group size register width

	localparam logic [1:0] OP_FORMAT  = 2'd0;
	localparam logic [1:0] OP_ALLOC   = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	localparam logic REG_TOTAL = 1'b0;
	localparam logic REG_GROUP = 1'b1;

	typedef struct packed {
		logic [1:0]    op;
		logic [BW-1:0] block_in;
	} cmd_t;

	typedef struct packed {
		logic [BW-1:0] block_out;
		logic [1:0]    status;
		logic [BW-1:0] free_left;
	} res_t;

	typedef struct packed {
		logic [BW-1:0] total_blocks;
		logic [GW-1:0] group_size;
	} cfg_regs_t;

	typedef struct packed {
		logic idle;
		logic done;
	} core_st_t;

endpackage

### design/gfba_cfg.sv
// APB-style register file: total_blocks and group_size.
// Depends on gfba_pkg for the register indexes and the register struct.

module gfba_cfg import gfba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_regs_t   regs
);

	logic [BW-1:0] total_q;
	logic [GW-1:0] group_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= BW'(1023);
			group_q <= GW'(8);
		end else if (wr_en) begin
			case (paddr[2])
				REG_TOTAL: total_q <= pwdata[BW-1:0];
				REG_GROUP: group_q <= pwdata[GW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TOTAL: prdata = {{(32-BW){1'b0}}, total_q};
			REG_GROUP: prdata = {{(32-GW){1'b0}}, group_q};
			default:   prdata = '0;
		endcase
	end

	assign regs.total_blocks = total_q;
	assign regs.group_size   = group_q;

endmodule

### design/gfba_core.sv
// Sequencer of the allocator: stack memory, leader store, leader counts,
// and one slot counter shared by format, group load and stack spill.
// Depends on gfba_pkg.

module gfba_core import gfba_pkg::*; #(
	parameter int MAX_BLOCKS = 1024,
	parameter int MAX_GROUP  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_regs_t cfg,
	input  logic      start,
	input  cmd_t      cmd,
	input  logic      take,
	output core_st_t  st,
	output res_t      res
);

	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int SW = $clog2(MAX_GROUP);
	localparam int LW = $clog2(MAX_BLOCKS);
	localparam int AW = $clog2(MAX_BLOCKS * MAX_GROUP);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FGRP   = 4'd1;
	localparam logic [3:0] S_FWR    = 4'd2;
	localparam logic [3:0] S_APOP   = 4'd3;
	localparam logic [3:0] S_ALEAD  = 4'd4;
	localparam logic [3:0] S_ACNT   = 4'd5;
	localparam logic [3:0] S_ACOPY  = 4'd6;
	localparam logic [3:0] S_RSPILL = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	function automatic logic [LW-1:0] blk_idx(input logic [BW-1:0] b);
		logic [BW+LW-1:0] e;
		e = {{LW{1'b0}}, b};
		return e[LW-1:0];
	endfunction

	logic [3:0]    state_q;
	logic [CW-1:0] count_q;
	logic [BW-1:0] free_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] n_q;
	logic [BW:0]   cur_q;
	logic [BW:0]   val_q;
	logic [BW-1:0] lead_q;
	logic          dst_stack_q;
	logic          zero_q;
	logic [BW-1:0] bout_q;
	logic [1:0]    stat_q;

	// effective configuration
	logic [BW-1:0] t_eff;
	logic [CW-1:0] g_eff;

	always_comb begin
		if (cfg.total_blocks == '0)
			t_eff = BW'(1);
		else if (32'(cfg.total_blocks) > MAX_BLOCKS - 1)
			t_eff = BW'(MAX_BLOCKS - 1);
		else
			t_eff = cfg.total_blocks;
		if (cfg.group_size < GW'(2))
			g_eff = CW'(2);
		else if (32'(cfg.group_size) > MAX_GROUP)
			g_eff = CW'(MAX_GROUP);
		else
			g_eff = CW'(cfg.group_size);
	end

	// shared slot counter
	logic [CW-1:0] k_inc;
	logic [CW-1:0] k_dec;
	assign k_inc = k_q + CW'(1);
	assign k_dec = k_q - CW'(1);

	// memories
	logic [BW-1:0] stack_mem [MAX_GROUP];
	logic [BW-1:0] lead_mem  [MAX_BLOCKS*MAX_GROUP];
	logic [CW-1:0] cnt_mem   [MAX_BLOCKS];

	logic          st_we, st_re;
	logic [SW-1:0] st_waddr, st_raddr;
	logic [BW-1:0] st_wdata, st_rd_q;
	logic          ld_we, ld_re;
	logic [CW-1:0] ld_slot;
	logic [AW-1:0] ld_addr;
	logic [BW-1:0] ld_wdata, ld_rd_q;
	logic          cn_we, cn_re;
	logic [LW-1:0] cn_addr;
	logic [CW-1:0] cn_wdata, cn_rd_q;

	// format helpers
	logic [BW+1:0] grp_end;
	logic          grp_full;
	logic          fmt_zero_slot;
	logic          fmt_last;
	logic [BW-1:0] fmt_data;
	logic [CW-1:0] count_dec;

	assign grp_end  = (BW+2)'(cur_q) + (BW+2)'(g_eff);
	assign grp_full = grp_end <= (BW+2)'(t_eff) + (BW+2)'(1);
	assign fmt_zero_slot = zero_q && (k_q == '0);
	assign fmt_data = fmt_zero_slot ? '0 : val_q[BW-1:0];
	assign count_dec = count_q - CW'(1);

	always_comb begin
		if (!zero_q)
			fmt_last = (k_inc == g_eff);
		else if (k_q == '0)
			fmt_last = cur_q > (BW+1)'(t_eff);
		else
			fmt_last = val_q == (BW+1)'(t_eff);
	end

	assign ld_slot = (state_q == S_RSPILL) ? k_dec : k_q;
	assign ld_addr = AW'(32'(blk_idx(lead_q)) * MAX_GROUP + 32'(ld_slot));

	always_comb begin
		st_we    = 1'b0;
		st_re    = 1'b0;
		st_waddr = k_dec[SW-1:0];
		st_raddr = k_q[SW-1:0];
		st_wdata = ld_rd_q;
		ld_we    = 1'b0;
		ld_re    = 1'b0;
		ld_wdata = st_rd_q;
		cn_we    = 1'b0;
		cn_re    = 1'b0;
		cn_addr  = blk_idx(lead_q);
		cn_wdata = n_q;
		case (state_q)
			S_IDLE: begin
				if (start && cmd.op == OP_ALLOC && count_q != '0) begin
					st_re    = 1'b1;
					st_raddr = count_dec[SW-1:0];
				end
				if (start && cmd.op == OP_RELEASE && cmd.block_in != '0 &&
				    cmd.block_in <= t_eff && count_q < g_eff) begin
					st_we    = 1'b1;
					st_waddr = count_q[SW-1:0];
					st_wdata = cmd.block_in;
				end
			end
			S_FWR: begin
				if (dst_stack_q) begin
					st_we    = 1'b1;
					st_waddr = k_q[SW-1:0];
					st_wdata = fmt_data;
				end else begin
					ld_we    = 1'b1;
					ld_wdata = fmt_data;
				end
				if (fmt_last && !dst_stack_q) begin
					cn_we    = 1'b1;
					cn_wdata = k_inc;
				end
			end
			S_ALEAD: begin
				cn_re   = 1'b1;
				cn_addr = blk_idx(st_rd_q);
			end
			S_ACOPY: begin
				ld_re = k_q < n_q;
				st_we = k_q != '0;
			end
			S_RSPILL: begin
				st_re = k_q < n_q;
				ld_we = k_q != '0;
				if (k_q == n_q) begin
					cn_we    = 1'b1;
					st_we    = 1'b1;
					st_waddr = '0;
					st_wdata = lead_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we)
			stack_mem[st_waddr] <= st_wdata;
		if (st_re)
			st_rd_q <= stack_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (ld_we)
			lead_mem[ld_addr] <= ld_wdata;
		if (ld_re)
			ld_rd_q <= lead_mem[ld_addr];
	end

	always_ff @(posedge clk) begin
		if (cn_we)
			cnt_mem[cn_addr] <= cn_wdata;
		if (cn_re)
			cn_rd_q <= cnt_mem[cn_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			free_q      <= '0;
			k_q         <= '0;
			n_q         <= '0;
			cur_q       <= '0;
			val_q       <= '0;
			lead_q      <= '0;
			dst_stack_q <= 1'b0;
			zero_q      <= 1'b0;
			bout_q      <= '0;
			stat_q      <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						bout_q <= '0;
						stat_q <= ST_OK;
						case (cmd.op)
							OP_FORMAT: begin
								cur_q       <= (BW+1)'(1);
								dst_stack_q <= 1'b1;
								state_q     <= S_FGRP;
							end
							OP_ALLOC: begin
								if (count_q == '0) begin
									stat_q  <= ST_NOSPACE;
									state_q <= S_DONE;
								end else if (count_q > CW'(1)) begin
									count_q <= count_dec;
									state_q <= S_APOP;
								end else begin
									state_q <= S_ALEAD;
								end
							end
							OP_RELEASE: begin
								if (cmd.block_in == '0 || cmd.block_in > t_eff) begin
									stat_q  <= ST_RANGE;
									state_q <= S_DONE;
								end else if (count_q >= g_eff) begin
									lead_q  <= cmd.block_in;
									k_q     <= '0;
									n_q     <= count_q;
									state_q <= S_RSPILL;
								end else begin
									count_q <= count_q + CW'(1);
									if (free_q != '1)
										free_q <= free_q + BW'(1);
									state_q <= S_DONE;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_FGRP: begin
					zero_q  <= !grp_full;
					val_q   <= cur_q;
					k_q     <= '0;
					state_q <= S_FWR;
				end
				S_FWR: begin
					if (!fmt_zero_slot)
						val_q <= val_q + (BW+1)'(1);
					if (fmt_last) begin
						if (dst_stack_q)
							count_q <= k_inc;
						if (!zero_q) begin
							// next group hangs under this group's leader
							lead_q      <= cur_q[BW-1:0];
							cur_q       <= cur_q + (BW+1)'(g_eff);
							dst_stack_q <= 1'b0;
							state_q     <= S_FGRP;
						end else begin
							free_q  <= t_eff;
							state_q <= S_DONE;
						end
					end else begin
						k_q <= k_inc;
					end
				end
				S_APOP: begin
					bout_q <= st_rd_q;
					if (free_q != '0)
						free_q <= free_q - BW'(1);
					state_q <= S_DONE;
				end
				S_ALEAD: begin
					if (st_rd_q == '0 || 32'(st_rd_q) > MAX_BLOCKS - 1) begin
						stat_q  <= ST_NOSPACE;
						state_q <= S_DONE;
					end else begin
						lead_q  <= st_rd_q;
						state_q <= S_ACNT;
					end
				end
				S_ACNT: begin
					if (32'(cn_rd_q) > MAX_GROUP)
						n_q <= CW'(MAX_GROUP);
					else
						n_q <= cn_rd_q;
					k_q     <= '0;
					state_q <= S_ACOPY;
				end
				S_ACOPY: begin
					// read slot k, write slot k-1 from the previous read
					if (k_q == n_q) begin
						count_q <= n_q;
						bout_q  <= lead_q;
						if (free_q != '0)
							free_q <= free_q - BW'(1);
						state_q <= S_DONE;
					end else begin
						k_q <= k_inc;
					end
				end
				S_RSPILL: begin
					if (k_q == n_q) begin
						count_q <= CW'(1);
						if (free_q != '1)
							free_q <= free_q + BW'(1);
						state_q <= S_DONE;
					end else begin
						k_q <= k_inc;
					end
				end
				S_DONE: begin
					if (take)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign st.idle       = state_q == S_IDLE;
	assign st.done       = state_q == S_DONE;
	assign res.block_out = bout_q;
	assign res.status    = stat_q;
	assign res.free_left = free_q;

endmodule

### design/grouped_free_block_allocator_unit.sv
// Grouped free block allocator: top level with command and result channels.
// Depends on gfba_pkg, gfba_cfg and gfba_core.

// One command word is taken at a time; the block stalls its command side until
// the sequencer is back in idle, while a finished result may still wait in the
// output register. An allocate pops a block, reports no space when only the end
// mark is left, or hands out the leader and loads the group saved under it; a
// release pushes the block, or spills the full stack under the released block.
// Format writes every group, counting the closing group that holds the end mark.
// The stack memory and the leader store each have a single read and write port
// and move one block number per cycle through the shared slot counter. No
// clearing pass runs after reset, and nothing checks that a leader loaded by an
// allocate had its group and count written by format or a spill.

module grouped_free_block_allocator_unit import gfba_pkg::*; #(
	parameter int MAX_BLOCKS = 1024,
	parameter int MAX_GROUP  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_regs_t regs;
	core_st_t  core_st;
	res_t      core_res;
	res_t      res_q;
	logic      res_valid_q;
	logic      start;
	logic      load;

	gfba_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.regs    (regs)
	);

	gfba_core #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.MAX_GROUP  (MAX_GROUP)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (regs),
		.start  (start),
		.cmd    (cmd),
		.take   (load),
		.st     (core_st),
		.res    (core_res)
	);

	assign cmd_stall = !core_st.idle;
	assign start     = cmd_valid && core_st.idle;
	// move the finished word out when the output register is free or draining
	assign load      = core_st.done && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (load)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= core_res;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### bench/tb_grouped_free_block_allocator_unit.sv
// Self-checking bench for the grouped free block allocator top level.
// Depends on gfba_pkg and the unit; drives commands, results and the APB port.
`timescale 1ns / 1ps

module tb_grouped_free_block_allocator_unit;
	import gfba_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int SETTLE_CYCLES = 64;
	localparam int RANDOM_PHASES = 5;

	// Predicts the free list and keeps the words still owed by the unit.
	class free_list_scoreboard;
		logic [BW-1:0] total_reg = 10'd1023;
		logic [GW-1:0] group_reg = 5'd8;
		logic [BW-1:0] stack_q [16];
		int            stack_depth = 0;
		logic [BW-1:0] saved_group [1024][16];
		int            saved_depth [1024];
		bit            saved_valid [1024];
		logic [BW-1:0] scratch [16];
		int            free_blocks = 0;
		logic [BW-1:0] last_block;
		res_t          pending_results [$];
		int            errors = 0;

		function void write_reg(logic idx, logic [31:0] value);
			if (idx == REG_TOTAL) begin
				total_reg = value[BW-1:0];
			end else begin
				group_reg = value[GW-1:0];
			end
		endfunction

		function int eff_total();
			return (total_reg == 0) ? 1 : int'(total_reg);
		endfunction

		function int eff_group();
			if (group_reg < 2) return 2;
			if (group_reg > 16) return 16;
			return int'(group_reg);
		endfunction

		function bit full_group(int start, int t, int g);
			return start <= t && (t - start + 1) >= g;
		endfunction

		// Lay out the group that starts at start in scratch; return its depth.
		function int fill_group(int start, int t, int g);
			int n;
			int b;
			n = 0;
			if (full_group(start, t, g)) begin
				for (b = 0; b < g; b++) begin
					scratch[n] = BW'(start + b);
					n++;
				end
			end else begin
				scratch[0] = '0;
				n = 1;
				for (b = start; b <= t && n < 16; b++) begin
					scratch[n] = BW'(b);
					n++;
				end
			end
			return n;
		endfunction

		// An allocate now would load a group that was never saved.
		function bit alloc_needs_unsaved();
			return stack_depth == 1 && stack_q[0] != 0 && !saved_valid[stack_q[0]];
		endfunction

		function void apply_command(cmd_t item);
			res_t r;
			int   t;
			int   g;
			int   s;
			int   n;
			int   i;
			int   lead;
			r = '0;
			case (item.op)
				OP_FORMAT: begin
					t = eff_total();
					g = eff_group();
					stack_depth = fill_group(1, t, g);
					for (i = 0; i < stack_depth; i++) stack_q[i] = scratch[i];
					s = 1;
					while (full_group(s, t, g)) begin
						n = fill_group(s + g, t, g);
						for (i = 0; i < n; i++) saved_group[s][i] = scratch[i];
						saved_depth[s] = n;
						saved_valid[s] = 1'b1;
						s += g;
					end
					free_blocks = t;
				end
				OP_ALLOC: begin
					if (stack_depth == 0) begin
						r.status = ST_NOSPACE;
					end else if (stack_depth > 1) begin
						stack_depth--;
						r.block_out = stack_q[stack_depth];
					end else begin
						lead = stack_q[0];
						if (lead == 0) begin
							r.status = ST_NOSPACE;
						end else begin
							// hand out the leader, take over its saved group
							n = saved_depth[lead];
							for (i = 0; i < n; i++) stack_q[i] = saved_group[lead][i];
							stack_depth = n;
							r.block_out = BW'(lead);
						end
					end
					if (r.status == ST_OK && free_blocks > 0) free_blocks--;
				end
				OP_RELEASE: begin
					if (item.block_in == 0 || item.block_in > eff_total()) begin
						r.status = ST_RANGE;
					end else begin
						if (stack_depth >= eff_group()) begin
							// spill the stack under the freed block
							for (i = 0; i < stack_depth; i++)
								saved_group[item.block_in][i] = stack_q[i];
							saved_depth[item.block_in] = stack_depth;
							saved_valid[item.block_in] = 1'b1;
							stack_q[0] = item.block_in;
							stack_depth = 1;
						end else begin
							stack_q[stack_depth] = item.block_in;
							stack_depth++;
						end
						if (free_blocks < 1023) free_blocks++;
					end
				end
				default: ;
			endcase
			r.free_left = BW'(free_blocks);
			last_block = r.block_out;
			pending_results.insert(pending_results.size(), r);
		endfunction

		function void compare_field(string name, logic [BW-1:0] want, logic [BW-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected word block_out %0d status %0d free_left %0d",
					$time, got.block_out, got.status, got.free_left);
				return;
			end
			want = pending_results.pop_front();
			compare_field("block_out", want.block_out, got.block_out);
			compare_field("status", BW'(want.status), BW'(got.status));
			compare_field("free_left", want.free_left, got.free_left);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	cmd_t        cmd;
	logic        res_valid;
	logic        res_stall;
	res_t        res;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	free_list_scoreboard free_list;
	bit quiet = 1'b0;
	int cycles = 0;
	int handed_out [$];

	grouped_free_block_allocator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("grouped_free_block_allocator_unit verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) free_list.check_result(res);
	end

	// Result side: hold stall for a random count before each word.
	initial begin
		int hold;
		res_stall = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 16);
			if (hold > 0) begin
				res_stall = 1'b1;
				repeat (hold) @(negedge clk);
				res_stall = 1'b0;
			end
			do @(posedge clk); while (!res_valid);
			@(negedge clk);
		end
	end

	function automatic cmd_t make_cmd(logic [1:0] op, int blk);
		cmd_t c;
		c.op = op;
		c.block_in = BW'(blk);
		return c;
	endfunction

	task automatic send_cmd(cmd_t item);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			cmd_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd = item;
		cmd_valid = 1'b1;
		do @(posedge clk); while (cmd_stall);
		free_list.apply_command(item);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		cmd_valid = 1'b0;
		while (free_list.pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic idx, input logic [31:0] data,
			output logic [31:0] rd);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = {idx, 2'b00};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic reg_write(logic idx, logic [31:0] value);
		logic [31:0] rd;
		logic [31:0] want;
		apb_access(1'b1, idx, value, rd);
		free_list.write_reg(idx, value);
		apb_access(1'b0, idx, 32'd0, rd);
		want = (idx == REG_TOTAL) ? (value & 32'h3FF) : (value & 32'h1F);
		if (rd !== want) begin
			free_list.errors++;
			$display("%0t: register %0d readback expected %0d, got %0d", $time, idx, want, rd);
		end
	endtask

	task automatic set_config(int total, int group);
		wait_drained();
		reg_write(REG_TOTAL, total);
		reg_write(REG_GROUP, group);
	endtask

	task automatic run_directed();
		set_config(1023, 8);
		send_cmd(make_cmd(OP_ALLOC, $urandom_range(0, 1023)));	// nothing formatted yet
		send_cmd(make_cmd(OP_UNUSED, $urandom_range(0, 1023)));
		send_cmd(make_cmd(OP_RELEASE, 0));
		send_cmd(make_cmd(OP_RELEASE, 1023));
		send_cmd(make_cmd(OP_FORMAT, 0));
		send_cmd(make_cmd(OP_RELEASE, 5));	// count pinned at 1023, stack spills
		send_cmd(make_cmd(OP_ALLOC, 1023));
		send_cmd(make_cmd(OP_ALLOC, 0));
		set_config(0, 1);
		send_cmd(make_cmd(OP_FORMAT, 1023));
		send_cmd(make_cmd(OP_ALLOC, 0));
		send_cmd(make_cmd(OP_ALLOC, 0));	// only the end mark is left
		send_cmd(make_cmd(OP_RELEASE, 2));
		send_cmd(make_cmd(OP_RELEASE, 1));
		send_cmd(make_cmd(OP_RELEASE, 1));	// released twice, not caught
		repeat (3) send_cmd(make_cmd(OP_ALLOC, $urandom_range(0, 1023)));
		set_config(1023, 31);
		send_cmd(make_cmd(OP_FORMAT, 0));
		// shrink the group below the live stack without a new format
		wait_drained();
		reg_write(REG_GROUP, 2);
		send_cmd(make_cmd(OP_RELEASE, 7));
		send_cmd(make_cmd(OP_ALLOC, 0));
		send_cmd(make_cmd(OP_ALLOC, 1023));
		send_cmd(make_cmd(OP_RELEASE, 1023));
		send_cmd(make_cmd(OP_UNUSED, 1023));
	endtask

	task automatic run_phase(int items);
		int   i;
		int   r;
		int   idx;
		int   total;
		int   group;
		int   alloc_pct;
		cmd_t item;
		case ($urandom_range(0, 9))
			0: total = 1023;
			1: total = 1;
			2: total = 0;
			3: total = $urandom_range(0, 1023);
			default: total = $urandom_range(2, 80);
		endcase
		case ($urandom_range(0, 3))
			0: group = $urandom_range(0, 31);
			1: group = 16;
			default: group = $urandom_range(2, 16);
		endcase
		set_config(total, group);
		quiet = ($urandom_range(0, 3) == 0);
		alloc_pct = $urandom_range(30, 60);
		handed_out.delete();
		send_cmd(make_cmd(OP_FORMAT, $urandom_range(0, 1023)));
		for (i = 0; i < items; i++) begin
			if ($urandom_range(0, 59) == 0) wait_drained();
			if (i == items / 2 && $urandom_range(0, 1) == 1) begin
				wait_drained();
				reg_write(REG_GROUP, $urandom_range(0, 31));
				if ($urandom_range(0, 2) == 0) reg_write(REG_TOTAL, $urandom_range(0, 1023));
			end
			r = $urandom_range(0, 99);
			if (r < alloc_pct && !free_list.alloc_needs_unsaved()) begin
				item = make_cmd(OP_ALLOC, $urandom_range(0, 1023));
			end else if (r < 88) begin
				if (handed_out.size() > 0) begin
					idx = $urandom_range(0, handed_out.size() - 1);
					item = make_cmd(OP_RELEASE, handed_out[idx]);
					handed_out.delete(idx);
				end else begin
					item = make_cmd(OP_RELEASE, $urandom_range(1, free_list.eff_total()));
				end
			end else if (r < 94) begin
				item = make_cmd(OP_RELEASE, $urandom_range(0, 1023));
			end else if (r < 97) begin
				item = make_cmd(OP_UNUSED, $urandom_range(0, 1023));
			end else begin
				item = make_cmd(OP_FORMAT, $urandom_range(0, 1023));
				handed_out.delete();
			end
			send_cmd(item);
			if (item.op == OP_ALLOC && free_list.last_block != 0)
				handed_out.insert(handed_out.size(), free_list.last_block);
		end
	endtask

	// Saturate the count high, then empty the list so it saturates at zero.
	task automatic run_drain();
		int g;
		int k;
		int picks [3];
		g = $urandom_range(2, 16);
		set_config(1023, g);
		quiet = ($urandom_range(0, 1) == 0);
		send_cmd(make_cmd(OP_FORMAT, $urandom_range(0, 1023)));
		// release distinct blocks off the leader slots of full groups so the
		// chain never loops back on itself
		for (k = 0; k < 3; k++) begin
			do begin
				picks[k] = 1 + g * int'($urandom_range(0, 1022 / g - 1))
					+ int'($urandom_range(1, g - 1));
			end while ((k > 0 && picks[k] == picks[0]) || (k > 1 && picks[k] == picks[1]));
			send_cmd(make_cmd(OP_RELEASE, picks[k]));
		end
		while (!(free_list.stack_depth == 1 && free_list.stack_q[0] == 0))
			send_cmd(make_cmd(OP_ALLOC, $urandom_range(0, 1023)));
		repeat (3) send_cmd(make_cmd(OP_ALLOC, $urandom_range(0, 1023)));
	endtask

	initial begin
		int p;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		free_list = new();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		run_directed();
		for (p = 0; p < RANDOM_PHASES; p++) run_phase($urandom_range(100, 200));
		run_drain();
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (free_list.errors == 0 && free_list.pending_results.size() == 0) begin
			$display("grouped_free_block_allocator_unit verification clean");
		end else begin
			$display("grouped_free_block_allocator_unit verification failed");
		end
		$finish;
	end

endmodule

### grouped_free_block_allocator_unit.f
design/gfba_pkg.sv
design/gfba_cfg.sv
design/gfba_core.sv
design/grouped_free_block_allocator_unit.sv
bench/tb_grouped_free_block_allocator_unit.sv
